### rtl/core/tileable_value_noise_texel_core_defines.svh
// Assertion macros used by the texel core top level.
`ifndef TILEABLE_VALUE_NOISE_TEXEL_CORE_DEFINES_SVH
`define TILEABLE_VALUE_NOISE_TEXEL_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define TVNT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tvnt: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define TVNT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tvnt: next-cycle check failed");

`endif

### rtl/core/tvnt_pkg.sv
// Shared types, constants and helper functions of the texel core.
package tvnt_pkg;

    localparam int COORD_BITS = 12;
    localparam int TEX_W      = 13;
    localparam int VAR_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_TEX_SIZE        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_VARIANT = 2'd1;

    localparam logic [TEX_W-1:0] TEX_SIZE_RESET = 13'd256;

    // integer coordinate width; IX_W is the lattice index width after the largest octave shift
    localparam int INT_W    = 18;
    localparam int IX_W     = 20;
    localparam int PER_W    = 15;
    localparam int NOISE_W  = 16;
    localparam int SMOOTH_W = 17;

    localparam int N_OCT     = 5;
    localparam int CLUMP_OCT = 3;

    localparam int AX_LAT  = IX_W + 1;
    localparam int OCT_LAT = 5;
    localparam int SHD_LAT = 5;

    localparam logic [31:0] HASH_MUL_X = 32'd374761393;
    localparam logic [31:0] HASH_MUL_Y = 32'd668265263;
    localparam logic [31:0] HASH_MIX   = 32'd1274126177;

    // reciprocals for division by constants: floor(n * RCP >> SHIFT)
    localparam logic [19:0] RCP_7       = 20'd599187;
    localparam int          RCP_7_SH    = 22;
    localparam logic [18:0] RCP_3       = 19'd349526;
    localparam int          RCP_3_SH    = 20;
    localparam logic [23:0] RCP_100     = 24'd10737419;
    localparam int          RCP_100_SH  = 30;
    localparam logic [13:0] RCP_CH      = 14'd10486;
    localparam int          RCP_CH_SH   = 20;
    localparam logic [19:0] RCP_P100    = 20'd671089;
    localparam int          RCP_P100_SH = 26;
    localparam logic [20:0] RCP_P10     = 21'd1677722;
    localparam int          RCP_P10_SH  = 24;

    localparam logic [1:0] LVL_DARK  = 2'd0;
    localparam logic [1:0] LVL_MID   = 2'd1;
    localparam logic [1:0] LVL_LIGHT = 2'd2;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
    } t_texel_in;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_texel_out;

    // one lattice axis: wrapped corner indices and smoothstep weight
    typedef struct packed {
        logic [PER_W-1:0]    x0;
        logic [PER_W-1:0]    x1;
        logic [SMOOTH_W-1:0] s;
    } t_axis;

    // palette color in hundredths, element 0 red, 1 green, 2 blue
    typedef logic [2:0][5:0] t_pal_rgb;

    function automatic t_pal_rgb pal_color(input logic [1:0] sel, input logic [1:0] lvl);
        t_pal_rgb c;
        case ({sel, lvl})
            4'b00_00: c = {6'd4,  6'd14, 6'd6};
            4'b00_01: c = {6'd9,  6'd26, 6'd13};
            4'b00_10: c = {6'd14, 6'd38, 6'd22};
            4'b01_00: c = {6'd3,  6'd13, 6'd10};
            4'b01_01: c = {6'd6,  6'd24, 6'd22};
            4'b01_10: c = {6'd10, 6'd34, 6'd36};
            4'b10_00: c = {6'd5,  6'd9,  6'd3};
            4'b10_01: c = {6'd10, 6'd17, 6'd7};
            4'b10_10: c = {6'd16, 6'd26, 6'd12};
            4'b11_00: c = {6'd11, 6'd13, 6'd5};
            4'b11_01: c = {6'd20, 6'd24, 6'd10};
            4'b11_10: c = {6'd29, 6'd35, 6'd17};
            default:  c = '0;
        endcase
        return c;
    endfunction

    // (a*(1-s) + b*s) in Q0.16
    function automatic logic [NOISE_W-1:0] lerp16(input logic [NOISE_W-1:0] a,
                                                 input logic [NOISE_W-1:0] b,
                                                 input logic [SMOOTH_W-1:0] s);
        logic [32:0] acc;
        acc = 33'(a) * (33'(17'h10000) - 33'(s)) + 33'(b) * 33'(s);
        return acc[31:16];
    endfunction

endpackage

### rtl/core/tvnt_axis.sv
// One lattice axis: pipelined wrap remainder and smoothstep weight.
module tvnt_axis import tvnt_pkg::*; #(
    parameter int FRAC_BITS = 16,
    parameter int SHIFT     = 0
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [INT_W+FRAC_BITS-1:0] i_coord,
    input  logic [PER_W-1:0]           i_period,
    output t_axis                      o_axis
);

    localparam int CW = INT_W + FRAC_BITS;
    localparam int WW = CW + 2;

    logic [WW-1:0]          w_wide;
    logic [IX_W-1:0]        w_ix;
    logic [FRAC_BITS-1:0]   w_frac;
    logic [FRAC_BITS+15:0]  w_tx;
    logic [15:0]            w_t;
    logic [31:0]            w_tsq;
    logic [PER_W:0]         w_per;

    logic [PER_W-1:0] w_rin   [IX_W];
    logic [IX_W-1:0]  w_din   [IX_W];
    logic [PER_W:0]   w_trial [IX_W];
    logic [PER_W-1:0] r_rem   [IX_W];
    logic [IX_W-1:0]  r_div   [IX_W-1];

    logic [PER_W:0]     w_inc;
    logic [PER_W-1:0]   r_x0;
    logic [PER_W-1:0]   r_x1;

    logic [15:0]         r_t;
    logic [15:0]         r_t2;
    logic [17:0]         w_wgt;
    logic [33:0]         w_sprod;
    logic [SMOOTH_W-1:0] r_s [AX_LAT-1];

    assign w_wide = {2'b00, i_coord} << SHIFT;
    assign w_ix   = w_wide[FRAC_BITS +: IX_W];
    assign w_frac = w_wide[FRAC_BITS-1:0];
    assign w_tx   = {w_frac, 16'h0000} >> FRAC_BITS;
    assign w_t    = w_tx[15:0];
    assign w_tsq  = 32'(w_t) * 32'(w_t);
    assign w_per  = {1'b0, i_period};

    // one quotient bit per stage, the remainder stays below the period
    always_comb begin
        w_rin[0] = '0;
        w_din[0] = w_ix;
        for (int k = 1; k < IX_W; k++) begin
            w_rin[k] = r_rem[k-1];
            w_din[k] = r_div[k-1];
        end
        for (int k = 0; k < IX_W; k++) begin
            w_trial[k] = {w_rin[k], w_din[k][IX_W-1-k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < IX_W; k++) begin
                if (w_trial[k] >= w_per) begin
                    r_rem[k] <= PER_W'(w_trial[k] - w_per);
                end else begin
                    r_rem[k] <= PER_W'(w_trial[k]);
                end
            end
            for (int k = 0; k < IX_W - 1; k++) begin
                r_div[k] <= w_din[k];
            end
        end
    end

    assign w_inc = {1'b0, r_rem[IX_W-1]} + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x0 <= r_rem[IX_W-1];
            r_x1 <= (w_inc == w_per) ? '0 : PER_W'(w_inc);
        end
    end

    assign w_wgt   = 18'h30000 - {1'b0, r_t, 1'b0};
    assign w_sprod = 34'(r_t2) * 34'(w_wgt);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t  <= w_t;
            r_t2 <= w_tsq[31:16];
            r_s[0] <= w_sprod[32:16];
            for (int k = 1; k < AX_LAT - 1; k++) begin
                r_s[k] <= r_s[k-1];
            end
        end
    end

    assign o_axis = '{x0: r_x0, x1: r_x1, s: r_s[AX_LAT-2]};

endmodule

### rtl/core/tvnt_octave.sv
// One octave: hash the four lattice corners and blend them bilinearly.
module tvnt_octave import tvnt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  t_axis              i_ax,
    input  t_axis              i_ay,
    output logic [NOISE_W-1:0] o_noise
);

    logic [PER_W-1:0] w_cx [4];
    logic [PER_W-1:0] w_cy [4];
    logic [31:0]      w_sum [4];
    logic [31:0]      w_fin [4];
    logic [NOISE_W-1:0] w_val [4];

    logic [31:0] r_px [4];
    logic [31:0] r_py [4];
    logic [31:0] r_h  [4];
    logic [31:0] r_m  [4];

    logic [SMOOTH_W-1:0] r_sx [3];
    logic [SMOOTH_W-1:0] r_sy [4];
    logic [NOISE_W-1:0]  r_la;
    logic [NOISE_W-1:0]  r_lb;
    logic [NOISE_W-1:0]  r_n;

    // corners: (x0,y0) (x1,y0) (x0,y1) (x1,y1)
    always_comb begin
        w_cx[0] = i_ax.x0;  w_cy[0] = i_ay.x0;
        w_cx[1] = i_ax.x1;  w_cy[1] = i_ay.x0;
        w_cx[2] = i_ax.x0;  w_cy[2] = i_ay.x1;
        w_cx[3] = i_ax.x1;  w_cy[3] = i_ay.x1;
        for (int c = 0; c < 4; c++) begin
            w_sum[c] = r_px[c] + r_py[c];
            w_fin[c] = r_m[c] ^ (r_m[c] >> 16);
            w_val[c] = w_fin[c][23:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 4; c++) begin
                r_px[c] <= 32'(w_cx[c]) * HASH_MUL_X;
                r_py[c] <= 32'(w_cy[c]) * HASH_MUL_Y;
                r_h[c]  <= w_sum[c] ^ (w_sum[c] >> 13);
                r_m[c]  <= r_h[c] * HASH_MIX;
            end
            r_sx[0] <= i_ax.s;
            r_sx[1] <= r_sx[0];
            r_sx[2] <= r_sx[1];
            r_sy[0] <= i_ay.s;
            r_sy[1] <= r_sy[0];
            r_sy[2] <= r_sy[1];
            r_sy[3] <= r_sy[2];
            r_la <= lerp16(w_val[0], w_val[1], r_sx[2]);
            r_lb <= lerp16(w_val[2], w_val[3], r_sx[2]);
            r_n  <= lerp16(r_la, r_lb, r_sy[3]);
        end
    end

    assign o_noise = r_n;

endmodule

### rtl/core/tvnt_shade.sv
// Fractal sums, noise blend and palette mix down to an RGB texel.
module tvnt_shade import tvnt_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [1:0]                    i_sel,
    input  logic [N_OCT-1:0][NOISE_W-1:0] i_noise,
    output t_texel_out                    o_texel
);

    logic [18:0] w_cs;
    logic [17:0] w_sp;
    logic [38:0] r_cp;
    logic [36:0] r_sp;
    logic [15:0] w_cl;
    logic [15:0] w_sk;
    logic [22:0] r_mix;
    logic [46:0] r_tp;

    logic [16:0] w_t17;
    logic [15:0] w_t;
    logic [15:0] w_u;
    t_pal_rgb    w_lo;
    t_pal_rgb    w_hi;
    logic [22:0] r_ch [3];

    logic [30:0] w_sc [3];
    logic [28:0] w_q  [3];
    logic [7:0]  w_c8 [3];
    t_texel_out  r_texel;

    assign w_cs = (19'(i_noise[0]) << 2) + (19'(i_noise[1]) << 1) + 19'(i_noise[2]);
    assign w_sp = (18'(i_noise[3]) << 1) + 18'(i_noise[4]);

    assign w_cl = r_cp[RCP_7_SH +: 16];
    assign w_sk = r_sp[RCP_3_SH +: 16];

    assign w_t17 = r_tp[RCP_100_SH +: 17];
    assign w_t   = (w_t17 > 17'd65535) ? 16'hFFFF : w_t17[15:0];
    // lower half and upper half both map to u = 2t mod 65536
    assign w_u   = {w_t[14:0], 1'b0};
    assign w_lo  = pal_color(i_sel, w_t[15] ? LVL_MID : LVL_DARK);
    assign w_hi  = pal_color(i_sel, w_t[15] ? LVL_LIGHT : LVL_MID);

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_sc[c] = (31'(r_ch[c]) << 8) - 31'(r_ch[c]);
            w_q[c]  = 29'(w_sc[c][30:16]) * 29'(RCP_CH);
            w_c8[c] = (w_q[c][28:RCP_CH_SH] > 9'd255) ? 8'hFF : w_q[c][RCP_CH_SH +: 8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cp  <= 39'(w_cs) * 39'(RCP_7);
            r_sp  <= 37'(w_sp) * 37'(RCP_3);
            r_mix <= 23'(w_cl) * 23'(7'd55) + 23'(w_sk) * 23'(6'd45);
            r_tp  <= 47'(r_mix) * 47'(RCP_100);
            for (int c = 0; c < 3; c++) begin
                r_ch[c] <= 23'(w_lo[c]) * (23'(17'h10000) - 23'(w_u)) + 23'(w_hi[c]) * 23'(w_u);
            end
            r_texel <= '{red: w_c8[0], green: w_c8[1], blue: w_c8[2]};
        end
    end

    assign o_texel = r_texel;

endmodule

### rtl/core/tileable_value_noise_texel_core.sv
// Top level of the tileable value-noise texel core.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------------
//   in      | sink      | i_in_valid / o_in_stall | t_texel_in  (pixel x, y)
//   out     | source    | o_out_valid/i_out_stall | t_texel_out (red,green,blue)
//   cfg     | sink      | i_cfg_we                | i_cfg_idx, i_cfg_data
//
// One texel per clock while the skid register is empty; the 20-stage wrap
// remainder in each lattice axis makes up most of the pipeline depth.
// Reset is synchronous, active low: it clears valid bits and restores
// tex_size = 256, palette_variant = 0; payload registers are not reset.
// A stalled output parks one texel in a skid register; o_in_stall is that
// register's valid bit, so the whole pipeline holds only while it is full.
`include "tileable_value_noise_texel_core_defines.svh"

module tileable_value_noise_texel_core import tvnt_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  t_texel_in             i_in_data,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output t_texel_out            o_out_data,
    input  logic                  i_out_stall,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW       = INT_W + FRAC_BITS;
    localparam int PIPE_LAT = 2 + AX_LAT + OCT_LAT + SHD_LAT;

    // fixed-point scale and offset constants, rounded to nearest
    localparam logic [63:0] K64_0P15  = ((64'd15 << FRAC_BITS) + 64'd50) / 64'd100;
    localparam logic [63:0] K64_0P9   = ((64'd9 << FRAC_BITS) + 64'd5) / 64'd10;
    localparam logic [63:0] K64_17P3  = ((64'd173 << FRAC_BITS) + 64'd5) / 64'd10;
    localparam logic [63:0] K64_52P6  = ((64'd526 << FRAC_BITS) + 64'd5) / 64'd10;
    localparam logic [63:0] K64_191P3 = ((64'd1913 << FRAC_BITS) + 64'd5) / 64'd10;
    localparam logic [63:0] K64_307P9 = ((64'd3079 << FRAC_BITS) + 64'd5) / 64'd10;

    localparam logic [CW-1:0] K_0P15  = CW'(K64_0P15);
    localparam logic [CW-1:0] K_0P9   = CW'(K64_0P9);
    localparam logic [CW-1:0] K_17P3  = CW'(K64_17P3);
    localparam logic [CW-1:0] K_52P6  = CW'(K64_52P6);
    localparam logic [CW-1:0] K_191P3 = CW'(K64_191P3);
    localparam logic [CW-1:0] K_307P9 = CW'(K64_307P9);

    // clumps period: round(tex_size * 0.15 * 2^sh), at least 1
    function automatic logic [PER_W-1:0] clump_period(input logic [TEX_W-1:0] ts,
                                                     input logic [1:0] sh);
        logic [19:0]      num;
        logic [41:0]      prod;
        logic [PER_W-1:0] q;
        num  = ((20'(ts) * 20'd15) << sh) + 20'd50;
        prod = 42'(num) * 42'(RCP_P100);
        q    = prod[RCP_P100_SH +: PER_W];
        return (q == '0) ? PER_W'(1) : q;
    endfunction

    // speckle period: round(tex_size * 0.9 * 2^sh), at least 1
    function automatic logic [PER_W-1:0] speck_period(input logic [TEX_W-1:0] ts,
                                                     input logic [1:0] sh);
        logic [19:0]      num;
        logic [41:0]      prod;
        logic [PER_W-1:0] q;
        num  = ((20'(ts) * 20'd9) << sh) + 20'd5;
        prod = 42'(num) * 42'(RCP_P10);
        q    = prod[RCP_P10_SH +: PER_W];
        return (q == '0) ? PER_W'(1) : q;
    endfunction

    logic [TEX_W-1:0] r_tex_size;
    logic [VAR_W-1:0] r_variant;
    logic [PER_W-1:0] r_per [N_OCT];

    logic                w_en;
    logic [PIPE_LAT-1:0] r_vld;
    t_texel_in           r_pix;

    logic [CW-1:0] w_px;
    logic [CW-1:0] w_py;
    logic [CW-1:0] w_ox;
    logic [CW-1:0] w_oy;
    logic [CW-1:0] r_cx_cl;
    logic [CW-1:0] r_cy_cl;
    logic [CW-1:0] r_cx_sp;
    logic [CW-1:0] r_cy_sp;

    logic [N_OCT-1:0][NOISE_W-1:0] w_noise;
    t_texel_out                    w_texel;

    logic       w_load_out;
    logic       r_out_valid;
    logic       r_skid_valid;
    t_texel_out r_out;
    t_texel_out r_skid;

    // configuration writes; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_size <= TEX_SIZE_RESET;
            r_variant  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TEX_SIZE:        r_tex_size <= i_cfg_data[TEX_W-1:0];
                REG_PALETTE_VARIANT: r_variant  <= i_cfg_data[VAR_W-1:0];
                default: ;
            endcase
        end
    end

    // wrap periods are registered from tex_size and follow it in the next cycle,
    // ahead of any item's first use in the axis remainder stages
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < CLUMP_OCT; k++) begin
            r_per[k] <= clump_period(r_tex_size, 2'(k));
        end
        for (int k = CLUMP_OCT; k < N_OCT; k++) begin
            r_per[k] <= speck_period(r_tex_size, 2'(k - CLUMP_OCT));
        end
    end

    // every stage advances unless the skid register holds a texel
    assign w_en = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pix <= i_in_data;
        end
    end

    // noise-space coordinates; the variant offset is taken straight from
    // its register so a write just before an item is seen
    assign w_px = CW'(r_pix.pixel_x);
    assign w_py = CW'(r_pix.pixel_y);
    assign w_ox = CW'(r_variant) * K_191P3;
    assign w_oy = CW'(r_variant) * K_307P9;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cx_cl <= w_px * K_0P15 + w_ox;
            r_cy_cl <= w_py * K_0P15 + w_oy;
            r_cx_sp <= w_px * K_0P9 + K_17P3 + w_ox;
            r_cy_sp <= w_py * K_0P9 + K_52P6 + w_oy;
        end
    end

    // octaves 0..2 are clumps, 3..4 speckle; clump octave i scales by 2^i, speckle octave i by 2^(i-3)
    for (genvar gi = 0; gi < N_OCT; gi++) begin : g_oct
        logic [CW-1:0] w_lx;
        logic [CW-1:0] w_ly;
        t_axis         w_ax;
        t_axis         w_ay;

        if (gi < CLUMP_OCT) begin : g_cl
            assign w_lx = r_cx_cl;
            assign w_ly = r_cy_cl;
        end else begin : g_sp
            assign w_lx = r_cx_sp;
            assign w_ly = r_cy_sp;
        end

        tvnt_axis #(
            .FRAC_BITS(FRAC_BITS),
            .SHIFT    ((gi < CLUMP_OCT) ? gi : gi - CLUMP_OCT)
        ) u_ax_x (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_coord (w_lx),
            .i_period(r_per[gi]),
            .o_axis  (w_ax)
        );

        tvnt_axis #(
            .FRAC_BITS(FRAC_BITS),
            .SHIFT    ((gi < CLUMP_OCT) ? gi : gi - CLUMP_OCT)
        ) u_ax_y (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_coord (w_ly),
            .i_period(r_per[gi]),
            .o_axis  (w_ay)
        );

        tvnt_octave u_oct (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_ax   (w_ax),
            .i_ay   (w_ay),
            .o_noise(w_noise[gi])
        );
    end

    tvnt_shade u_shade (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_sel  (r_variant[1:0]),
        .i_noise(w_noise),
        .o_texel(w_texel)
    );

    // output register plus skid: the pipeline sees only a registered stall
    assign w_load_out = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_en) begin
            if (w_load_out) begin
                r_out_valid <= r_vld[PIPE_LAT-1];
            end else begin
                r_skid_valid <= r_vld[PIPE_LAT-1];
            end
        end else if (w_load_out) begin
            r_out_valid  <= 1'b1;
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_load_out) begin
                r_out <= w_texel;
            end else begin
                r_skid <= w_texel;
            end
        end else if (w_load_out) begin
            r_out <= r_skid;
        end
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // an accepted transaction lands in the first stage
    `TVNT_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_vld[0])
    // the skid only fills behind a held output texel
    `TVNT_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    // a parked texel survives a continued stall unchanged
    `TVNT_ASSERT_NEXT(a_skid_holds, i_clk, i_rst_n, r_skid_valid && i_out_stall, r_skid_valid && $stable(r_skid))

endmodule

### dv/testbench.sv
// Self-checking testbench for the tileable value-noise texel core.
module testbench;
    import tvnt_pkg::*;

    localparam int  DRAIN_CYCLES = 40;      // longer than the pipeline
    localparam longint CYCLE_LIMIT = 600000;
    localparam longint K_0P15  = ((15 << 16) + 50) / 100;
    localparam longint K_0P9   = ((9 << 16) + 5) / 10;
    localparam longint K_17P3  = ((173 << 16) + 5) / 10;
    localparam longint K_52P6  = ((526 << 16) + 5) / 10;
    localparam longint K_191P3 = ((1913 << 16) + 5) / 10;
    localparam longint K_307P9 = ((3079 << 16) + 5) / 10;

    // register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    t_texel_in             i_in_data;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_texel_out            o_out_data;
    logic                  i_out_stall;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    tileable_value_noise_texel_core DUT (.*);

    // palette colors in hundredths: [palette][dark, mid, light][r, g, b]
    int unsigned leaf_colors [4][3][3] = '{
        '{'{6, 14, 4}, '{13, 26, 9}, '{22, 38, 14}},
        '{'{10, 13, 3}, '{22, 24, 6}, '{36, 34, 10}},
        '{'{3, 9, 5}, '{7, 17, 10}, '{12, 26, 16}},
        '{'{5, 13, 11}, '{10, 24, 20}, '{17, 35, 29}}
    };

    logic [TEX_W-1:0] tex_size_q;
    logic [VAR_W-1:0] variant_q;
    t_texel_out       expected_texels[$];
    int               mismatches;
    longint           cycle_count;
    int               burst_left;
    int               stall_mode;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Abort on a hung handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver stalls on a pattern of its own: free run, light or heavy stall.
    always @(posedge i_clk) begin
        if ($urandom_range(0, 199) == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            default: i_out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Compare each output transaction with the oldest expected texel.
    always @(posedge i_clk) begin
        t_texel_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_texels.size() == 0) begin
                $error("unexpected texel %h", o_out_data);
                mismatches++;
            end else begin
                want = expected_texels.pop_front();
                if (o_out_data.red !== want.red) begin
                    $error("red: expected %0d, got %0d", want.red, o_out_data.red);
                    mismatches++;
                end
                if (o_out_data.green !== want.green) begin
                    $error("green: expected %0d, got %0d", want.green, o_out_data.green);
                    mismatches++;
                end
                if (o_out_data.blue !== want.blue) begin
                    $error("blue: expected %0d, got %0d", want.blue, o_out_data.blue);
                    mismatches++;
                end
            end
        end
    end

    function automatic longint unsigned corner_hash(longint unsigned ix, longint unsigned iy);
        logic [31:0] h;
        h = ix[31:0] * 32'd374761393 + iy[31:0] * 32'd668265263;
        h = (h ^ (h >> 13)) * 32'd1274126177;
        h = h ^ (h >> 16);
        return (h & 32'hFFFFFF) >> 8;
    endfunction

    function automatic longint unsigned mix16(longint unsigned a, longint unsigned b,
                                              longint unsigned s);
        return (a * (65536 - s) + b * s) >> 16;
    endfunction

    function automatic longint unsigned fade(longint unsigned coord);
        longint unsigned t, t2;
        t  = coord & 16'hFFFF;
        t2 = (t * t) >> 16;
        return (t2 * (3 * 65536 - 2 * t)) >> 16;
    endfunction

    function automatic longint unsigned lattice_period(longint unsigned num,
                                                       longint unsigned den, int sh);
        longint unsigned p;
        p = (((longint'(tex_size_q) * num) << sh) + den / 2) / den;
        return (p == 0) ? 1 : p;
    endfunction

    function automatic longint unsigned noise_octave(longint unsigned cx, longint unsigned cy,
                                                     int sh, longint unsigned per);
        longint unsigned ix, iy, sx, sy, x0, x1, y0, y1, a, b;
        cx = cx << sh;
        cy = cy << sh;
        ix = cx >> 16;
        iy = cy >> 16;
        sx = fade(cx);
        sy = fade(cy);
        x0 = ix % per;
        x1 = (ix + 1) % per;
        y0 = iy % per;
        y1 = (iy + 1) % per;
        a = mix16(corner_hash(x0, y0), corner_hash(x1, y0), sx);
        b = mix16(corner_hash(x0, y1), corner_hash(x1, y1), sx);
        return mix16(a, b, sy);
    endfunction

    function automatic t_texel_out leaf_texel(logic [COORD_BITS-1:0] px,
                                              logic [COORD_BITS-1:0] py);
        longint unsigned ox, oy, cx, cy, clumps, speckle, t, u, c;
        int lo, hi, sel;
        logic [2:0][7:0] rgb;
        ox = longint'(variant_q) * K_191P3;
        oy = longint'(variant_q) * K_307P9;
        cx = longint'(px) * K_0P15 + ox;
        cy = longint'(py) * K_0P15 + oy;
        clumps = (4 * noise_octave(cx, cy, 0, lattice_period(15, 100, 0))
                + 2 * noise_octave(cx, cy, 1, lattice_period(15, 100, 1))
                + noise_octave(cx, cy, 2, lattice_period(15, 100, 2))) / 7;
        cx = longint'(px) * K_0P9 + K_17P3 + ox;
        cy = longint'(py) * K_0P9 + K_52P6 + oy;
        speckle = (2 * noise_octave(cx, cy, 0, lattice_period(9, 10, 0))
                 + noise_octave(cx, cy, 1, lattice_period(9, 10, 1))) / 3;
        t = (clumps * 55 + speckle * 45) / 100;
        if (t > 65535) t = 65535;
        sel = int'(variant_q[1:0]);
        if (t < 32768) begin
            u = 2 * t; lo = 0; hi = 1;
        end else begin
            u = 2 * t - 65536; lo = 1; hi = 2;
        end
        for (int ch = 0; ch < 3; ch++) begin
            c = (leaf_colors[sel][lo][ch] * (65536 - u) + leaf_colors[sel][hi][ch] * u) * 255;
            c = c / (100 * 65536);
            if (c > 255) c = 255;
            rgb[2-ch] = c[7:0];
        end
        return t_texel_out'(rgb);
    endfunction

    // Send one pixel: bursts of random length, mostly separated by random gaps.
    task automatic send_pixel(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 2) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= '{pixel_x: px, pixel_y: py};
        do @(posedge i_clk); while (o_in_stall);
        expected_texels.push_back(leaf_texel(px, py));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_texels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write a register while the pipeline is empty.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_TEX_SIZE) tex_size_q = data;
        else if (idx == REG_PALETTE_VARIANT) variant_q = data[VAR_W-1:0];
    endtask

    task automatic test_reset_defaults();
        send_pixel(12'd0, 12'd0);
        send_pixel(12'hFFF, 12'hFFF);
        send_pixel(12'd255, 12'd0);
        send_pixel(12'd0, 12'd255);
        send_pixel(12'hAAA, 12'h555);
    endtask

    // Hit size and variant extremes, unknown indexes and over-wide data.
    task automatic test_register_extremes();
        logic [CFG_DATA_W-1:0] sizes [6] = '{13'd0, 13'd1, 13'd3, 13'd4096, 13'h1FFF, 13'd7};
        foreach (sizes[i]) begin
            write_reg(REG_TEX_SIZE, sizes[i]);
            write_reg(REG_PALETTE_VARIANT, (i % 2) ? 13'h1FFF : 13'd0);
            send_pixel(12'd0, 12'd0);
            send_pixel(12'hFFF, 12'h000);
            send_pixel(sizes[i][11:0], 12'hFFF);
        end
        write_reg(REG_SPARE_2, 13'd5);
        write_reg(REG_SPARE_3, 13'h1234);
        for (int v = 0; v < 4; v++) begin
            write_reg(REG_PALETTE_VARIANT, 13'(v));
            send_pixel(12'd100, 12'd200);
        end
    endtask

    task automatic test_random_pixels();
        for (int phase = 0; phase < 10; phase++) begin
            write_reg(REG_TEX_SIZE, ($urandom_range(0, 9) == 0) ? 13'($urandom)
                                                             : 13'($urandom_range(1, 4096)));
            write_reg(REG_PALETTE_VARIANT, 13'($urandom));
            for (int n = 0; n < 90; n++) begin
                // hold off until every texel is back, once per phase
                if (n == 45) wait_drained();
                if ($urandom_range(0, 3) == 0)
                    send_pixel(12'($urandom), 12'($urandom));
                else
                    send_pixel(12'($urandom_range(0, tex_size_q > 4096 ? 4095
                                                     : (tex_size_q == 0 ? 0 : tex_size_q - 1))),
                               12'($urandom_range(0, 4095)));
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_stall = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        cycle_count = 0;
        mismatches  = 0;
        burst_left  = 0;
        stall_mode  = 0;
        tex_size_q  = TEX_SIZE_RESET;
        variant_q   = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_register_extremes();
        test_random_pixels();
        wait_drained();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

### files.f
+incdir+rtl/core
rtl/core/tvnt_pkg.sv
rtl/core/tvnt_axis.sv
rtl/core/tvnt_octave.sv
rtl/core/tvnt_shade.sv
rtl/core/tileable_value_noise_texel_core.sv
dv/testbench.sv
